// ----- rtl/core/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// Types, constants and register codes shared by the spectrum peak segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

	// longest spectrum; the bin at index MAX_BINS-1 always closes the spectrum
	localparam int unsigned MAX_BINS = 65536;
	localparam int unsigned IDX_W    = $clog2(MAX_BINS);
	localparam int unsigned LEN_W    = IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BINS - 1);

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DETECT_MODE   = 3'd0,
		CFG_ABS_THRESHOLD = 3'd1,
		CFG_NSIGMA_GAIN   = 3'd2,
		CFG_NSIGMA_OFFSET = 3'd3,
		CFG_MIN_BINS      = 3'd4
	} cfg_idx_t;

	localparam logic MODE_ABS    = 1'b0;
	localparam logic MODE_NSIGMA = 1'b1;

	// register reset values
	localparam logic [15:0] NSIGMA_GAIN_RST = 16'd768;

	// one histogram bin
	typedef struct packed {
		logic signed [31:0] bin_signal;
		logic        [30:0] bin_error;
		logic               last_bin;
	} bin_t;

	// one reported run
	typedef struct packed {
		logic        [15:0] run_start;
		logic        [15:0] run_stop;
		logic        [15:0] peak_index;
		logic signed [31:0] peak_signal;
		logic        [16:0] run_length;
	} run_t;

endpackage

`default_nettype wire

// ----- rtl/core/sps_stream_if.sv -----
// ----------------------------------------------------------------------------
// sps_bin_if / sps_run_if
// Valid/ready channels carrying input bins and reported runs.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_bin_if;
	import sps_pkg::*;

	logic valid;
	logic ready;
	bin_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface sps_run_if;
	import sps_pkg::*;

	logic valid;
	logic ready;
	run_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/spectrum_peak_segmenter_unit.sv -----
// ----------------------------------------------------------------------------
// spectrum_peak_segmenter_unit
// Streams histogram bins, finds peak runs by absolute threshold or n-sigma
// rise/drop, and reports start, stop, peak and length of closed runs of >= min_bins bins.
// ----------------------------------------------------------------------------
// Pipeline: a run that closes on a bin passes the input register, the bound
//   register, then the result register before it is valid on the output.
// Throughput: one bin per cycle; the input stalls only while the result
//   register holds an item the sink has not taken and the pipe behind it is full.
// Reset: arst_n clears run state, bin counter and pipeline valids, and loads
//   the configuration registers with their defaults.
`default_nettype none

module spectrum_peak_segmenter_unit
	import sps_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	sps_bin_if.sink                    bin_in,
	sps_run_if.source                  run_out
);

	// configuration registers
	logic               detect_mode_q;
	logic signed [31:0] abs_threshold_q;
	logic        [15:0] nsigma_gain_q;
	logic        [30:0] nsigma_offset_q;
	logic        [15:0] min_bins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_mode_q   <= MODE_ABS;
			abs_threshold_q <= '0;
			nsigma_gain_q   <= NSIGMA_GAIN_RST;
			nsigma_offset_q <= '0;
			min_bins_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DETECT_MODE:   detect_mode_q   <= cfg_wdata[0];
				CFG_ABS_THRESHOLD: abs_threshold_q <= cfg_wdata[31:0];
				CFG_NSIGMA_GAIN:   nsigma_gain_q   <= cfg_wdata[15:0];
				CFG_NSIGMA_OFFSET: nsigma_offset_q <= cfg_wdata[30:0];
				CFG_MIN_BINS:      min_bins_q      <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// pipeline handshake
	logic v_s1, v_s2, out_v_q;
	logic fire2, adv1, take;

	assign fire2        = v_s2 && (!out_v_q || run_out.ready);
	assign adv1         = v_s1 && (!v_s2 || fire2);
	assign bin_in.ready = !v_s1 || adv1;
	assign take         = bin_in.valid && bin_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take)
				v_s1 <= 1'b1;
			else if (adv1)
				v_s1 <= 1'b0;
			if (adv1)
				v_s2 <= 1'b1;
			else if (fire2)
				v_s2 <= 1'b0;
		end
	end

	// stage 1: input register
	logic signed [31:0] signal_s1;
	logic        [30:0] error_s1;
	logic               last_s1;

	always_ff @(posedge clk) begin
		if (take) begin
			signal_s1 <= bin_in.data.bin_signal;
			error_s1  <= bin_in.data.bin_error;
			last_s1   <= bin_in.data.last_bin;
		end
	end

	// stage 2: significance bound gain*error + 256*offset (Q8.8 scale)
	logic [46:0]        prod;
	logic [47:0]        bound_d;
	logic signed [31:0] signal_s2;
	logic               last_s2;
	logic [47:0]        bound_s2;

	assign prod    = 47'(nsigma_gain_q) * 47'(error_s1);
	assign bound_d = {1'b0, prod} + {9'd0, nsigma_offset_q, 8'd0};

	always_ff @(posedge clk) begin
		if (adv1) begin
			signal_s2 <= signal_s1;
			last_s2   <= last_s1;
			bound_s2  <= bound_d;
		end
	end

	// run state
	logic               in_run_q;
	logic [IDX_W-1:0]   bin_count_q;
	logic [IDX_W-1:0]   start_pos_q;
	logic signed [31:0] start_level_q;
	logic [IDX_W-1:0]   best_pos_q;
	logic signed [31:0] best_level_q;
	logic signed [31:0] prev_level_q;
	logic               prev_valid_q;

	// decision logic
	logic               in_run_d;
	logic [IDX_W-1:0]   bin_count_d;
	logic [IDX_W-1:0]   start_pos_d;
	logic signed [31:0] start_level_d;
	logic [IDX_W-1:0]   best_pos_d;
	logic signed [31:0] best_level_d;
	logic signed [31:0] prev_level_d;
	logic               prev_valid_d;
	logic               closing, emit, last;
	logic [IDX_W-1:0]   stop_pos;
	logic [LEN_W-1:0]   run_len;
	logic signed [32:0] delta;
	logic signed [49:0] diff, ndiff, bound;
	logic               above, rise, drop, ends;

	assign delta = {signal_s2[31], signal_s2} - {prev_level_q[31], prev_level_q};
	assign diff  = {{9{delta[32]}}, delta, 8'd0};
	assign ndiff = -diff;
	assign bound = {2'b00, bound_s2};
	assign rise  = diff > bound;
	assign drop  = ndiff > bound;
	assign above = signal_s2 >= abs_threshold_q;
	assign ends  = drop || (in_run_q && (start_level_q > signal_s2));
	assign last  = last_s2 || (bin_count_q == LAST_IDX);

	always_comb begin
		in_run_d      = in_run_q;
		start_pos_d   = start_pos_q;
		start_level_d = start_level_q;
		best_pos_d    = best_pos_q;
		best_level_d  = best_level_q;
		closing       = 1'b0;
		stop_pos      = bin_count_q - IDX_W'(1);

		// open, track or close on this bin
		if ((detect_mode_q == MODE_ABS) || prev_valid_q) begin
			if (!in_run_q && ((detect_mode_q == MODE_ABS) ? above : rise)) begin
				in_run_d      = 1'b1;
				start_pos_d   = bin_count_q;
				start_level_d = signal_s2;
				best_pos_d    = bin_count_q;
				best_level_d  = signal_s2;
			end else if (in_run_q && ((detect_mode_q == MODE_ABS) ? !above : ends)) begin
				in_run_d = 1'b0;
				closing  = 1'b1;
			end else if (in_run_q && (signal_s2 > best_level_q)) begin
				best_pos_d   = bin_count_q;
				best_level_d = signal_s2;
			end
		end

		prev_level_d = signal_s2;
		prev_valid_d = 1'b1;
		bin_count_d  = bin_count_q + IDX_W'(1);

		// end of spectrum: an open run closes including this bin
		if (last) begin
			if (in_run_d) begin
				closing  = 1'b1;
				stop_pos = bin_count_q;
			end
			in_run_d     = 1'b0;
			prev_valid_d = 1'b0;
			prev_level_d = '0;
			bin_count_d  = '0;
		end

		run_len = {1'b0, stop_pos} - {1'b0, start_pos_d} + LEN_W'(1);
		emit    = closing && !(run_len < LEN_W'(min_bins_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q      <= 1'b0;
			bin_count_q   <= '0;
			start_pos_q   <= '0;
			start_level_q <= '0;
			best_pos_q    <= '0;
			best_level_q  <= '0;
			prev_level_q  <= '0;
			prev_valid_q  <= 1'b0;
		end else if (fire2) begin
			in_run_q      <= in_run_d;
			bin_count_q   <= bin_count_d;
			start_pos_q   <= start_pos_d;
			start_level_q <= start_level_d;
			best_pos_q    <= best_pos_d;
			best_level_q  <= best_level_d;
			prev_level_q  <= prev_level_d;
			prev_valid_q  <= prev_valid_d;
		end
	end

	// result register
	run_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (fire2 && emit)
			out_v_q <= 1'b1;
		else if (run_out.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire2 && emit) begin
			out_q.run_start   <= 16'(start_pos_d);
			out_q.run_stop    <= 16'(stop_pos);
			out_q.peak_index  <= 16'(best_pos_d);
			out_q.peak_signal <= best_level_d;
			out_q.run_length  <= 17'(run_len);
		end
	end

	assign run_out.valid = out_v_q;
	assign run_out.data  = out_q;

endmodule

`default_nettype wire
